// ===== design/prq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants
// Opcodes, status codes, queue sizing and the control/datapath interface.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int MAX_TASKS = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int ID_W      = 5;
    localparam int PRI_W     = 8;
    localparam int QT_W      = 16;

    typedef enum logic [1:0] {
        OP_READY    = 2'd0,
        OP_QUANTUM  = 2'd1,
        OP_SCHEDULE = 2'd2,
        OP_DISPATCH = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_IDLE  = 2'd2,
        ST_NORUN = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;     // latch request fields
        logic do_insert;   // insert the latched or running task
        logic insert_run;  // insert source is the running task
        logic do_pop;      // pop head into running
        logic set_quantum; // set quantum-over flag
    } prq_cmd_t;

    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic                   head_higher; // head priority above running
        logic                   running_valid;
        logic                   quantum_over;
        logic                   exc;
        opcode_t                op;
    } prq_stat_t;

endpackage

// ===== design/priority_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler: preemptive priority scheduler, top level
// Each request goes through accept (S_IDLE), then decide and update of the sorted
// cell chain (S_EXEC), then result handoff (S_HOLD). No new request is accepted
// until the previous result is taken; the ready queue is a chain of MAX_TASKS
// cells that shifts in parallel on an insert or a pop.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler
    import prq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic [ID_W-1:0]         task_id,
    input  logic signed [PRI_W-1:0] task_priority,
    input  logic                    except_pending,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    switch_needed,
    output logic                    run_valid,
    output logic [ID_W-1:0]         run_task,
    output logic signed [PRI_W-1:0] run_priority,
    output logic [QT_W-1:0]         slice_ticks,
    output logic [1:0]              status,
    input  logic                    cfg_we,
    input  logic [QT_W-1:0]         cfg_wdata
);

    logic [QT_W-1:0]         quantum_reg;
    prq_cmd_t                cmd;
    prq_stat_t               stat;
    logic [ID_W-1:0]         head_id;
    logic signed [PRI_W-1:0] head_pri;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quantum_reg <= QT_W'(4);
        else if (cfg_we)
            quantum_reg <= cfg_wdata;
    end

    prq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .quantum_ticks (quantum_reg),
        .cmd           (cmd),
        .stat          (stat),
        .head_id       (head_id),
        .head_pri      (head_pri),
        .switch_needed (switch_needed),
        .run_valid     (run_valid),
        .run_task      (run_task),
        .run_priority  (run_priority),
        .slice_ticks   (slice_ticks),
        .status        (status)
    );

    prq_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .task_id        (task_id),
        .task_priority  (task_priority),
        .except_pending (except_pending),
        .head_id        (head_id),
        .head_pri       (head_pri)
    );

endmodule

// ===== design/prq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_datapath: sorted ready queue and running task state
// A chain of cells kept sorted by priority; insert and pop shift the chain in parallel.
// ----------------------------------------------------------------------------
module prq_datapath
    import prq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  prq_cmd_t                cmd,
    output prq_stat_t               stat,
    input  logic [1:0]              opcode,
    input  logic [ID_W-1:0]         task_id,
    input  logic signed [PRI_W-1:0] task_priority,
    input  logic                    except_pending,
    output logic [ID_W-1:0]         head_id,
    output logic signed [PRI_W-1:0] head_pri
);

    logic [ID_W-1:0]         id_reg   [MAX_TASKS];
    logic signed [PRI_W-1:0] pri_reg  [MAX_TASKS];
    logic [CNT_W-1:0]        count_reg;
    logic [ID_W-1:0]         run_id_reg;
    logic signed [PRI_W-1:0] run_pri_reg;
    logic                    run_valid_reg;
    logic                    qover_reg;
    logic [31:0]             disp_cnt_reg;
    logic [1:0]              op_reg;
    logic [ID_W-1:0]         in_id_reg;
    logic signed [PRI_W-1:0] in_pri_reg;
    logic                    exc_reg;

    logic [ID_W-1:0]         ins_id;
    logic signed [PRI_W-1:0] ins_pri;
    logic [MAX_TASKS-1:0]    behind;

    assign ins_id  = cmd.insert_run ? run_id_reg  : in_id_reg;
    assign ins_pri = cmd.insert_run ? run_pri_reg : in_pri_reg;

    // cell i keeps its place when it is valid and ranks at or above the new entry
    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            behind[i] = (CNT_W'(i) < count_reg) && (pri_reg[i] >= ins_pri);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (cmd.do_insert && !behind[i])
            begin
                if (i == 0 || behind[i-1])
                begin
                    id_reg[i]  <= ins_id;
                    pri_reg[i] <= ins_pri;
                end
                else
                begin
                    id_reg[i]  <= id_reg[i-1];
                    pri_reg[i] <= pri_reg[i-1];
                end
            end
            else if (cmd.do_pop && i < MAX_TASKS - 1)
            begin
                id_reg[i]  <= id_reg[i+1];
                pri_reg[i] <= pri_reg[i+1];
            end
        end
        if (cmd.capture)
        begin
            op_reg     <= opcode;
            in_id_reg  <= task_id;
            in_pri_reg <= task_priority;
            exc_reg    <= except_pending;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            run_id_reg    <= '0;
            run_pri_reg   <= '0;
            run_valid_reg <= 1'b0;
            qover_reg     <= 1'b0;
            disp_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.set_quantum)
                qover_reg <= 1'b1;
            if (cmd.do_insert)
            begin
                count_reg <= count_reg + 1'b1;
                if (cmd.insert_run)
                    run_valid_reg <= 1'b0;
            end
            else if (cmd.do_pop)
            begin
                count_reg     <= count_reg - 1'b1;
                run_id_reg    <= id_reg[0];
                run_pri_reg   <= pri_reg[0];
                run_valid_reg <= 1'b1;
                qover_reg     <= 1'b0;
                disp_cnt_reg  <= disp_cnt_reg + 32'd1;
            end
        end
    end

    assign head_id  = id_reg[0];
    assign head_pri = pri_reg[0];

    always_comb
    begin
        stat.full          = (count_reg == CNT_W'(MAX_TASKS));
        stat.empty         = (count_reg == '0);
        stat.head_higher   = (pri_reg[0] > run_pri_reg);
        stat.running_valid = run_valid_reg;
        stat.quantum_over  = qover_reg;
        stat.exc           = exc_reg;
        stat.op            = opcode_t'(op_reg);
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_insert && cmd.do_pop))
        else $error("insert and pop together");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |=> run_valid_reg)
        else $error("pop did not set running");

endmodule

// ===== design/prq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_ctrl: request sequencer
// Takes a request, decides in the next cycle, holds the result until taken.
// ----------------------------------------------------------------------------
module prq_ctrl
    import prq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  logic [QT_W-1:0]         quantum_ticks,
    output prq_cmd_t                cmd,
    input  prq_stat_t               stat,
    input  logic [ID_W-1:0]         head_id,
    input  logic signed [PRI_W-1:0] head_pri,
    output logic                    switch_needed,
    output logic                    run_valid,
    output logic [ID_W-1:0]         run_task,
    output logic signed [PRI_W-1:0] run_priority,
    output logic [QT_W-1:0]         slice_ticks,
    output logic [1:0]              status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                    sw_reg, rv_reg;
    logic [ID_W-1:0]         rt_reg;
    logic signed [PRI_W-1:0] rp_reg;
    logic [QT_W-1:0]         sl_reg;
    status_t                 st_reg;

    logic    pre;
    logic    sw_d, rv_d;
    status_t st_d;
    logic    exec;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_HOLD);
    assign exec      = (state_reg == S_EXEC);

    always_comb
    begin
        if (stat.exc)
            pre = 1'b1;
        else if (stat.empty)
            pre = 1'b0;
        else if (!stat.head_higher)
            pre = stat.quantum_over;
        else
            pre = 1'b1;
    end

    always_comb
    begin
        cmd  = '0;
        sw_d = 1'b0;
        rv_d = 1'b0;
        st_d = ST_OK;
        cmd.capture = in_valid && in_ready;
        if (exec)
        begin
            case (stat.op)
                OP_READY:
                begin
                    if (stat.full)
                        st_d = ST_FULL;
                    else
                        cmd.do_insert = 1'b1;
                end
                OP_QUANTUM:
                    cmd.set_quantum = 1'b1;
                OP_SCHEDULE:
                begin
                    if (!stat.running_valid)
                        st_d = ST_NORUN;
                    else if (pre)
                    begin
                        if (stat.full)
                            st_d = ST_FULL;
                        else
                        begin
                            cmd.do_insert  = 1'b1;
                            cmd.insert_run = 1'b1;
                            sw_d           = 1'b1;
                        end
                    end
                end
                OP_DISPATCH:
                begin
                    if (stat.empty)
                        st_d = ST_IDLE;
                    else
                    begin
                        cmd.do_pop = 1'b1;
                        rv_d       = 1'b1;
                    end
                end
                default:
                    st_d = ST_OK;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_EXEC;
            S_EXEC:  state_next = S_HOLD;
            S_HOLD:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            sw_reg <= sw_d;
            rv_reg <= rv_d;
            rt_reg <= rv_d ? head_id : '0;
            rp_reg <= rv_d ? head_pri : '0;
            sl_reg <= rv_d ? quantum_ticks : '0;
            st_reg <= st_d;
        end
    end

    assign switch_needed = sw_reg;
    assign run_valid     = rv_reg;
    assign run_task      = rt_reg;
    assign run_priority  = rp_reg;
    assign slice_ticks   = sl_reg;
    assign status        = st_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("accepting while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid)
        else $error("result not presented after execute");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_insert || cmd.do_pop || cmd.set_quantum) |-> exec)
        else $error("datapath command outside execute");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for priority_ready_queue_scheduler
// Drives random and directed scheduler requests with random idling on both
// channels, predicts every result with a behavioral scheduler model kept in a
// small class, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
    import prq_pkg::*;

    typedef struct packed {
        logic                    sw;
        logic                    rv;
        logic [ID_W-1:0]         tid;
        logic signed [PRI_W-1:0] pri;
        logic [QT_W-1:0]         slice;
        logic [1:0]              st;
    } sched_result_t;

    class sched_scoreboard;
        logic [ID_W-1:0]         q_id[$];
        logic signed [PRI_W-1:0] q_pri[$];
        logic [ID_W-1:0]         cur_id;
        logic signed [PRI_W-1:0] cur_pri;
        bit                      cur_valid;
        bit                      qover;
        logic [QT_W-1:0]         quantum;
        sched_result_t           pending[$];
        int                      errors;
        int                      checked;

        function new();
            quantum = 4;
            errors = 0;
            checked = 0;
            cur_valid = 0;
            qover = 0;
            cur_id = 0;
            cur_pri = 0;
        endfunction

        function bit ready_insert(logic [ID_W-1:0] id, logic signed [PRI_W-1:0] p);
            int pos;
            pos = 0;
            if (q_id.size() >= MAX_TASKS)
                return 0;
            while (pos < q_id.size() && q_pri[pos] >= p)
                pos++;
            q_id.insert(pos, id);
            q_pri.insert(pos, p);
            return 1;
        endfunction

        function void note_request(logic [1:0] op, logic [ID_W-1:0] id,
                                   logic signed [PRI_W-1:0] p, logic exc);
            sched_result_t r;
            bit pre;
            r = '0;
            case (opcode_t'(op))
                OP_READY:
                    if (!ready_insert(id, p))
                        r.st = ST_FULL;
                OP_QUANTUM:
                    qover = 1;
                OP_SCHEDULE:
                    if (!cur_valid)
                        r.st = ST_NORUN;
                    else
                    begin
                        if (exc)
                            pre = 1;
                        else if (q_id.size() == 0)
                            pre = 0;
                        else if (q_pri[0] <= cur_pri)
                            pre = qover;
                        else
                            pre = 1;
                        if (pre)
                        begin
                            if (ready_insert(cur_id, cur_pri))
                            begin
                                cur_valid = 0;
                                r.sw = 1;
                            end
                            else
                                r.st = ST_FULL;
                        end
                    end
                default:
                    if (q_id.size() == 0)
                        r.st = ST_IDLE;
                    else
                    begin
                        cur_id = q_id.pop_front();
                        cur_pri = q_pri.pop_front();
                        cur_valid = 1;
                        qover = 0;
                        r.rv = 1;
                        r.tid = cur_id;
                        r.pri = cur_pri;
                        r.slice = quantum;
                    end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t exp;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: exp sw=%b rv=%b id=%0d pri=%0d slice=%0d st=%0d",
                             exp.sw, exp.rv, exp.tid, exp.pri, exp.slice, exp.st);
                    $display("          got sw=%b rv=%b id=%0d pri=%0d slice=%0d st=%0d",
                             got.sw, got.rv, got.tid, got.pri, got.slice, got.st);
                end
            end
        endfunction
    endclass

    logic                    clk = 0;
    logic                    rst_n = 0;
    logic                    in_valid = 0;
    logic                    in_ready;
    logic [1:0]              opcode = '0;
    logic [ID_W-1:0]         task_id = '0;
    logic signed [PRI_W-1:0] task_priority = '0;
    logic                    except_pending = 0;
    logic                    out_valid;
    logic                    out_ready = 0;
    logic                    switch_needed;
    logic                    run_valid;
    logic [ID_W-1:0]         run_task;
    logic signed [PRI_W-1:0] run_priority;
    logic [QT_W-1:0]         slice_ticks;
    logic [1:0]              status;
    logic                    cfg_we = 0;
    logic [QT_W-1:0]         cfg_wdata = '0;

    sched_scoreboard sb = new();
    bit idling = 1;
    int n_ops[4];

    priority_ready_queue_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .task_id(task_id), .task_priority(task_priority),
        .except_pending(except_pending),
        .out_valid(out_valid), .out_ready(out_ready),
        .switch_needed(switch_needed), .run_valid(run_valid), .run_task(run_task),
        .run_priority(run_priority), .slice_ticks(slice_ticks), .status(status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result({switch_needed, run_valid, run_task, run_priority,
                             slice_ticks, status});

    // result-side stalls
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                k = $urandom_range(1, 10);
                repeat (k) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    task automatic send_request(logic [1:0] op, logic [ID_W-1:0] id,
                                logic signed [PRI_W-1:0] p, logic exc);
        int k;
        @(negedge clk);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            k = $urandom_range(1, 10);
            repeat (k) @(negedge clk);
        end
        in_valid <= 1;
        opcode <= op;
        task_id <= id;
        task_priority <= p;
        except_pending <= exc;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(op, id, p, exc);
        n_ops[op]++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_quantum(logic [QT_W-1:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.quantum = v;
    endtask

    task automatic random_request(int mode);
        int r;
        r = $urandom_range(0, 99);
        // mode 0 favors filling, 1 moves most ready weight to quantum requests
        if (r < (mode == 0 ? 55 : 20))
            send_request(OP_READY, ID_W'($urandom), PRI_W'($urandom), 1'($urandom));
        else if (r < 65)
            send_request(OP_QUANTUM, ID_W'($urandom), PRI_W'($urandom), 1'($urandom));
        else if (r < 80)
            send_request(OP_SCHEDULE, ID_W'($urandom), PRI_W'($urandom),
                         $urandom_range(0, 3) == 0);
        else
            send_request(OP_DISPATCH, ID_W'($urandom), PRI_W'($urandom), 1'($urandom));
    endtask

    initial
    begin
        logic [QT_W-1:0] qsets[5];
        qsets = '{16'd1, 16'hFFFF, 16'd0, 16'd4, 16'd37};
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed
        send_request(OP_SCHEDULE, 0, 0, 0);
        send_request(OP_DISPATCH, 0, 0, 0);
        send_request(OP_READY, 5'd31, -8'sd128, 1);
        send_request(OP_READY, 5'd0, 8'sd127, 0);
        send_request(OP_READY, 5'd7, 8'sd127, 0);
        send_request(OP_DISPATCH, 0, 0, 0);
        send_request(OP_SCHEDULE, 0, 0, 0);
        send_request(OP_QUANTUM, 0, 0, 0);
        send_request(OP_SCHEDULE, 0, 0, 0);
        send_request(OP_DISPATCH, 0, 0, 0);
        send_request(OP_SCHEDULE, 0, 0, 1);
        send_request(OP_DISPATCH, 0, 0, 0);
        send_request(OP_READY, 5'd3, 8'sd1, 0);
        send_request(OP_DISPATCH, 0, 0, 0);
        send_request(OP_DISPATCH, 0, 0, 0);
        send_request(OP_DISPATCH, 0, 0, 0);
        send_request(OP_DISPATCH, 0, 0, 0);
        for (int i = 0; i < MAX_TASKS + 1; i++)
            send_request(OP_READY, ID_W'(i), PRI_W'($urandom), 0);
        send_request(OP_DISPATCH, 0, 0, 0);
        send_request(OP_READY, 5'd9, 8'sd0, 0);
        send_request(OP_SCHEDULE, 0, 0, 1);
        send_request(OP_DISPATCH, 0, 0, 0);

        for (int ph = 0; ph < 5; ph++)
        begin
            write_quantum(qsets[ph]);
            for (int i = 0; i < 130; i++)
            begin
                if (ph == 4 && i == 100)
                    idling = 0;
                random_request((i / 35) % 2);
            end
        end
        drain();
        $display("covered %0d ready, %0d quantum, %0d schedule, %0d dispatch requests",
                 n_ops[0], n_ops[1], n_ops[2], n_ops[3]);
        $display("%0d results checked over five quantum settings, %0d errors",
                 sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== priority_ready_queue_scheduler.f =====
design/prq_pkg.sv
design/prq_datapath.sv
design/prq_ctrl.sv
design/priority_ready_queue_scheduler.sv
tb/sv/tb.sv
